@@ hdl/display_init_list_player_defines.svh @@
// Assertion macros shared by the checker of the init list player.
`ifndef DISPLAY_INIT_LIST_PLAYER_DEFINES_SVH
`define DISPLAY_INIT_LIST_PLAYER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DILP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DILP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/dilp_pkg.sv @@
package dilp_pkg;

   localparam logic [1:0] ACT_WRITE    = 2'd0;
   localparam logic [1:0] ACT_CMD_ONLY = 2'd1;
   localparam logic [1:0] ACT_DELAY    = 2'd2;
   localparam logic [1:0] ACT_END      = 2'd3;

   localparam logic [7:0] END_MARK_BYTE   = 8'hFF;
   localparam logic [7:0] LONG_DELAY_CODE = 8'hFF;
   localparam logic [9:0] LONG_DELAY_RESET = 10'd500;

   // One classified list entry on its way from the parser to the output stage.
   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] reg_address;
      logic [7:0]  write_data;
      logic [7:0]  delay_byte;
   } entry_type;

endpackage

@@ hdl/dilp_front.sv @@
module dilp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_list_byte,
   input  logic              queue_full,
   output logic              push,
   output dilp_pkg::entry_type push_entry
);
   import dilp_pkg::*;

   typedef enum logic [3:0] {
      PH_CMD   = 4'b0001,
      PH_COUNT = 4'b0010,
      PH_ARG   = 4'b0100,
      PH_DELAY = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] address_ff, address_in;
   logic [6:0]  args_left_ff, args_left_in;
   logic        delay_pending_ff, delay_pending_in;
   logic        accept;
   phase_type   after_body;

   assign req_stall  = queue_full;
   assign accept     = req_valid & ~queue_full;
   // On a count byte the delay flag comes straight from the byte, otherwise from the register.
   assign after_body = ((phase_ff == PH_COUNT) ? req_list_byte[7] : delay_pending_ff)
                       ? PH_DELAY : PH_CMD;

   always_comb begin
      phase_in         = phase_ff;
      address_in       = address_ff;
      args_left_in     = args_left_ff;
      delay_pending_in = delay_pending_ff;
      push             = 1'b0;
      push_entry       = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_CMD: begin
               address_in = {req_list_byte, 8'h00};
               phase_in   = PH_COUNT;
            end
            PH_COUNT: begin
               if (address_ff[15:8] == END_MARK_BYTE && req_list_byte == END_MARK_BYTE) begin
                  phase_in          = PH_CMD;
                  delay_pending_in  = 1'b0;
                  args_left_in      = '0;
                  push              = 1'b1;
                  push_entry.action = ACT_END;
               end else begin
                  delay_pending_in = req_list_byte[7];
                  if (req_list_byte[6:0] == 7'd0) begin
                     args_left_in           = '0;
                     phase_in               = after_body;
                     push                   = 1'b1;
                     push_entry.action      = ACT_CMD_ONLY;
                     push_entry.reg_address = address_ff;
                  end else begin
                     args_left_in = req_list_byte[6:0];
                     phase_in     = PH_ARG;
                  end
               end
            end
            PH_ARG: begin
               push                   = 1'b1;
               push_entry.action      = ACT_WRITE;
               push_entry.reg_address = address_ff;
               push_entry.write_data  = req_list_byte;
               address_in             = address_ff + 16'd1;
               args_left_in           = args_left_ff - 7'd1;
               if (args_left_ff == 7'd1) begin
                  phase_in = after_body;
               end
            end
            PH_DELAY: begin
               phase_in              = PH_CMD;
               delay_pending_in      = 1'b0;
               push                  = 1'b1;
               push_entry.action     = ACT_DELAY;
               push_entry.delay_byte = req_list_byte;
            end
            default: begin
               phase_in = PH_CMD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_CMD;
         address_ff       <= '0;
         args_left_ff     <= '0;
         delay_pending_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         address_ff       <= address_in;
         args_left_ff     <= args_left_in;
         delay_pending_ff <= delay_pending_in;
      end
   end

endmodule

@@ hdl/dilp_queue.sv @@
module dilp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dilp_pkg::entry_type push_entry,
   output logic                full,
   output logic                not_empty,
   input  logic                pop,
   output dilp_pkg::entry_type head_entry
);
   import dilp_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/dilp_back.sv @@
module dilp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  dilp_pkg::entry_type head_entry,
   output logic                pop,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [9:0]          csr_long_delay_ms,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_action,
   output logic [15:0]         rsp_reg_address,
   output logic [7:0]          rsp_write_data,
   output logic [9:0]          rsp_delay_ms
);
   import dilp_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic [9:0]  long_delay_ff;
   logic [1:0]  action_ff;
   logic [15:0] address_ff;
   logic [7:0]  data_ff;
   logic [9:0]  delay_ff, delay_in;

   assign csr_ready = 1'b1;

   // The output register refills from a non-empty queue whenever it is empty or being taken this cycle.
   assign pop = head_valid & (~out_valid_ff | ~rsp_stall);

   always_comb begin
      out_valid_in = out_valid_ff & rsp_stall;
      if (pop) begin
         out_valid_in = 1'b1;
      end
      delay_in = '0;
      if (head_entry.action == ACT_DELAY) begin
         delay_in = (head_entry.delay_byte == LONG_DELAY_CODE) ? long_delay_ff
                                                               : {2'b00, head_entry.delay_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         long_delay_ff <= LONG_DELAY_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            long_delay_ff <= csr_long_delay_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff  <= head_entry.action;
         address_ff <= head_entry.reg_address;
         data_ff    <= head_entry.write_data;
         delay_ff   <= delay_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = action_ff;
   assign rsp_reg_address = address_ff;
   assign rsp_write_data  = data_ff;
   assign rsp_delay_ms    = delay_ff;

endmodule

@@ hdl/display_init_list_player.sv @@
// Display init list player.
// The req channel takes one list byte per item: command byte, count byte (bit 7
// asks for a delay byte after the arguments), the arguments, the optional delay
// byte. The rsp channel gives one action per argument (register write), per
// zero count (command only), per delay byte (delay in ms) and per FF FF pair
// (end of list). Command and nonzero count bytes give no result.
// The csr channel writes the long delay (used for delay byte 255); it is always
// ready and is meant to be written while the block is idle.
// A result passes through the queue and then the output register before it is
// valid on rsp. Throughput: one byte per cycle while req_stall is low; the
// parser does a few small compares and a counter update per byte.
// A QUEUE_DEPTH entry queue sits between the parser and the output register.
// While rsp is stalled the parser keeps taking bytes until the queue fills,
// then req_stall rises; req_stall depends only on the queue fill, not on
// rsp_stall directly. Reset (synchronous) empties the queue and output
// register, returns the parser to expect a command byte and restores the long
// delay to 500 ms.
module display_init_list_player #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_list_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [15:0] rsp_reg_address,
   output logic [7:0]  rsp_write_data,
   output logic [9:0]  rsp_delay_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_long_delay_ms
);
   import dilp_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      queue_not_empty;
   logic      pop;
   entry_type head_entry;

   dilp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_list_byte (req_list_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   dilp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop        (pop),
      .head_entry (head_entry)
   );

   dilp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (queue_not_empty),
      .head_entry        (head_entry),
      .pop               (pop),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_long_delay_ms (csr_long_delay_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_reg_address   (rsp_reg_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_delay_ms      (rsp_delay_ms)
   );

endmodule

@@ hdl/dilp_checker.sv @@
`include "display_init_list_player_defines.svh"

module dilp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_action,
   input logic [15:0] rsp_reg_address,
   input logic [7:0]  rsp_write_data,
   input logic [9:0]  rsp_delay_ms
);
   import dilp_pkg::*;

   `DILP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_action) && $stable(rsp_reg_address)
         && $stable(rsp_write_data) && $stable(rsp_delay_ms),
      "stalled result changed")
   `DILP_ASSERT_NOW(a_no_addr,
      rsp_valid && (rsp_action == ACT_DELAY || rsp_action == ACT_END),
      rsp_reg_address == 16'd0 && rsp_write_data == 8'd0,
      "delay or end item carries address or data")
   `DILP_ASSERT_NOW(a_no_delay, rsp_valid && rsp_action != ACT_DELAY,
      rsp_delay_ms == 10'd0, "non-delay item carries a delay")
   `DILP_ASSERT_NOW(a_reset_clear, $past(reset), !rsp_valid && !req_stall,
      "block not empty after reset")

endmodule

bind display_init_list_player dilp_checker u_dilp_checker (.*);
